FILE: rtl/pcorr_pkg.sv
// Package for the Pearson correlation block: widths, limits, status codes
// and the sequencer's state and operation types. No dependencies.

package pcorr_pkg;

	localparam int MAX_POINTS  = 65536;
	localparam int SAMPLE_BITS = 24;

	localparam int CNT_W  = 17;   // pair counter
	localparam int SUM_W  = 40;   // sum of x, sum of y
	localparam int SQ_W   = 63;   // sums of squares
	localparam int XY_W   = 64;   // sum of products
	localparam int MUL_W  = 25;   // multiplier operands
	localparam int PROD_W = 2 * MUL_W;
	localparam int VAR_W  = 80;   // n*Sxx - Sx^2, numerator magnitude
	localparam int DEN_W  = 2 * VAR_W;
	localparam int ACC_W  = 192;  // shift-add accumulator
	localparam int MB_W   = VAR_W;
	localparam int T_W    = 32;   // (2m-1)^2 during the search
	localparam int STEP_W = 7;
	localparam int CODE_W = 16;
	localparam int BIT_W  = 4;

	localparam logic [CODE_W-1:0] R_ONE = 16'd32768;
	localparam logic [CODE_W-1:0] R_MAX = 16'd32767;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_FLAT = 2'd2,
		ST_OVER = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_PXY,
		S_ADDXY,
		S_CHECK,
		S_LOAD,
		S_RUN,
		S_POST,
		S_TSQ,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_DX1,
		OP_DX2,
		OP_DY1,
		OP_DY2,
		OP_NUM1,
		OP_NUM2,
		OP_NEG,
		OP_RHS,
		OP_DEN,
		OP_TEST
	} op_t;

endpackage

FILE: rtl/pearson_correlation.sv
// Pearson correlation block, top level.
// Depends on pcorr_pkg.

// Pairs (x, y) in Q8.16 are summed exactly; the word flagged last_pair closes the
// set and yields r = (n*Sxy - Sx*Sy) / sqrt((n*Sxx - Sx^2)(n*Syy - Sy^2)) in Q1.15,
// rounded to nearest, +1 saturating to 32767, with a status code and the pair
// count. Status: 0 ok, 1 fewer than two pairs, 2 zero variance, 3 more than
// 65536 pairs (extra pairs are dropped); r is 0 whenever status is not 0.
// Sequence: each pair passes through the states SQX, SQY, PXY and ADDXY (one
// 25x25 multiplier used three times in turn); a pair past the limit is taken in
// IDLE alone. After a last pair the variances, numerator, its square and the
// denominator are formed one multiplier bit per cycle by a 192-bit shift-add unit,
// and r is found by a 16-step bit search, each step a pass of that same unit unless
// the candidate exceeds one. Input is stalled throughout; a finished result waits
// in its output register while the next set is taken.

module pearson_correlation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x,
	input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic                                  last_pair,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [pcorr_pkg::CODE_W-1:0]   correlation,
	output logic [1:0]                            status,
	output logic [pcorr_pkg::CNT_W-1:0]           pair_count
);

	pcorr_pkg::state_t state_q, state_nxt;
	pcorr_pkg::op_t    op_q, op_nxt;

	logic [pcorr_pkg::CNT_W-1:0]        pair_cnt_q;
	logic signed [pcorr_pkg::SUM_W-1:0] sum_x_q, sum_y_q;
	logic [pcorr_pkg::SQ_W-1:0]         sum_xx_q, sum_yy_q;
	logic signed [pcorr_pkg::XY_W-1:0]  sum_xy_q;
	logic                               overflow_q;
	logic                               result_valid_q;

	logic signed [pcorr_pkg::SAMPLE_BITS-1:0] x_q, y_q;
	logic                                     last_q;
	logic signed [pcorr_pkg::PROD_W-1:0]      prod_s1;
	logic signed [pcorr_pkg::MUL_W-1:0]       mul_a, mul_b;

	logic [pcorr_pkg::ACC_W-1:0]  acc_q, ma_q, unit_sum, ld_ma;
	logic [pcorr_pkg::MB_W-1:0]   mb_q, ld_mb;
	logic [pcorr_pkg::STEP_W-1:0] cnt_q, ld_cnt;
	logic                         sub_q, ld_sub, ld_clr;

	logic [pcorr_pkg::VAR_W-1:0]  dx_q, dy_q, num_q;
	logic [pcorr_pkg::DEN_W-1:0]  den_q;
	logic [pcorr_pkg::ACC_W-1:0]  rhs_q;
	logic                         neg_q;
	logic [pcorr_pkg::CODE_W-1:0] m_q, cand, corr_val;
	logic [pcorr_pkg::BIT_W-1:0]  bit_q;
	logic [pcorr_pkg::CODE_W:0]   odd;
	logic                         cand_over, flat, take_word, capture;
	pcorr_pkg::status_t           status_q;

	logic signed [pcorr_pkg::CODE_W-1:0] corr_q;
	logic [1:0]                          res_status_q;
	logic [pcorr_pkg::CNT_W-1:0]         res_count_q;

	logic [pcorr_pkg::SUM_W-1:0] mag_x, mag_y;
	logic [pcorr_pkg::XY_W-1:0]  mag_xy;

	assign mag_x  = sum_x_q[pcorr_pkg::SUM_W-1] ? pcorr_pkg::SUM_W'(-sum_x_q) : sum_x_q;
	assign mag_y  = sum_y_q[pcorr_pkg::SUM_W-1] ? pcorr_pkg::SUM_W'(-sum_y_q) : sum_y_q;
	assign mag_xy = sum_xy_q[pcorr_pkg::XY_W-1] ? pcorr_pkg::XY_W'(-sum_xy_q) : sum_xy_q;

	assign cand      = m_q | (pcorr_pkg::CODE_W'(1) << bit_q);
	assign cand_over = cand > pcorr_pkg::R_ONE;
	assign odd       = {cand, 1'b0} - (pcorr_pkg::CODE_W + 1)'(1);
	assign flat      = (dx_q == '0) || (acc_q[pcorr_pkg::VAR_W-1:0] == '0);

	// shared add/subtract unit
	assign unit_sum = acc_q + (sub_q ? ~ma_q : ma_q) + pcorr_pkg::ACC_W'(sub_q);

	assign take_word = (state_q == pcorr_pkg::S_IDLE) && sample_valid;
	assign capture   = (state_q == pcorr_pkg::S_DONE) && (!result_valid_q || !result_stall);

	always_comb begin
		if (status_q != pcorr_pkg::ST_OK)
			corr_val = '0;
		else if (neg_q)
			corr_val = pcorr_pkg::CODE_W'(-m_q);
		else if (m_q > pcorr_pkg::R_MAX)
			corr_val = pcorr_pkg::R_MAX;
		else
			corr_val = m_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		op_nxt    = op_q;
		unique case (state_q)
			pcorr_pkg::S_IDLE: begin
				if (sample_valid) begin
					if (pair_cnt_q == pcorr_pkg::CNT_W'(pcorr_pkg::MAX_POINTS))
						state_nxt = last_pair ? pcorr_pkg::S_CHECK : pcorr_pkg::S_IDLE;
					else
						state_nxt = pcorr_pkg::S_SQX;
				end
			end
			pcorr_pkg::S_SQX:   state_nxt = pcorr_pkg::S_SQY;
			pcorr_pkg::S_SQY:   state_nxt = pcorr_pkg::S_PXY;
			pcorr_pkg::S_PXY:   state_nxt = pcorr_pkg::S_ADDXY;
			pcorr_pkg::S_ADDXY: state_nxt = last_q ? pcorr_pkg::S_CHECK : pcorr_pkg::S_IDLE;
			pcorr_pkg::S_CHECK: begin
				if (overflow_q || pair_cnt_q < pcorr_pkg::CNT_W'(2)) begin
					state_nxt = pcorr_pkg::S_DONE;
				end else begin
					op_nxt    = pcorr_pkg::OP_DX1;
					state_nxt = pcorr_pkg::S_LOAD;
				end
			end
			pcorr_pkg::S_LOAD: state_nxt = pcorr_pkg::S_RUN;
			pcorr_pkg::S_RUN: begin
				if (cnt_q == pcorr_pkg::STEP_W'(1))
					state_nxt = pcorr_pkg::S_POST;
			end
			pcorr_pkg::S_POST: begin
				state_nxt = pcorr_pkg::S_LOAD;
				unique case (op_q)
					pcorr_pkg::OP_DX1:  op_nxt = pcorr_pkg::OP_DX2;
					pcorr_pkg::OP_DX2:  op_nxt = pcorr_pkg::OP_DY1;
					pcorr_pkg::OP_DY1:  op_nxt = pcorr_pkg::OP_DY2;
					pcorr_pkg::OP_DY2: begin
						if (flat)
							state_nxt = pcorr_pkg::S_DONE;
						else
							op_nxt = pcorr_pkg::OP_NUM1;
					end
					pcorr_pkg::OP_NUM1: op_nxt = pcorr_pkg::OP_NUM2;
					pcorr_pkg::OP_NUM2: begin
						op_nxt = acc_q[pcorr_pkg::ACC_W-1] ? pcorr_pkg::OP_NEG
							: pcorr_pkg::OP_RHS;
					end
					pcorr_pkg::OP_NEG:  op_nxt = pcorr_pkg::OP_RHS;
					pcorr_pkg::OP_RHS:  op_nxt = pcorr_pkg::OP_DEN;
					pcorr_pkg::OP_DEN:  state_nxt = pcorr_pkg::S_TSQ;
					pcorr_pkg::OP_TEST: begin
						state_nxt = (bit_q == '0) ? pcorr_pkg::S_DONE : pcorr_pkg::S_TSQ;
					end
					default: state_nxt = pcorr_pkg::S_DONE;
				endcase
			end
			pcorr_pkg::S_TSQ: begin
				if (cand_over) begin
					state_nxt = (bit_q == '0) ? pcorr_pkg::S_DONE : pcorr_pkg::S_TSQ;
				end else begin
					op_nxt    = pcorr_pkg::OP_TEST;
					state_nxt = pcorr_pkg::S_LOAD;
				end
			end
			pcorr_pkg::S_DONE: begin
				if (!result_valid_q || !result_stall)
					state_nxt = pcorr_pkg::S_IDLE;
			end
			default: state_nxt = pcorr_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sample_stall = (state_q != pcorr_pkg::S_IDLE);
		mul_a = pcorr_pkg::MUL_W'(x_q);
		mul_b = pcorr_pkg::MUL_W'(x_q);
		unique case (state_q)
			pcorr_pkg::S_SQY: begin
				mul_a = pcorr_pkg::MUL_W'(y_q);
				mul_b = pcorr_pkg::MUL_W'(y_q);
			end
			pcorr_pkg::S_PXY: begin
				mul_a = pcorr_pkg::MUL_W'(x_q);
				mul_b = pcorr_pkg::MUL_W'(y_q);
			end
			pcorr_pkg::S_TSQ: begin
				mul_a = signed'(pcorr_pkg::MUL_W'(odd));
				mul_b = signed'(pcorr_pkg::MUL_W'(odd));
			end
			default: ;
		endcase

		ld_ma  = pcorr_pkg::ACC_W'(sum_xx_q);
		ld_mb  = pcorr_pkg::MB_W'(pair_cnt_q);
		ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::CNT_W);
		ld_sub = 1'b0;
		ld_clr = 1'b1;
		unique case (op_q)
			pcorr_pkg::OP_DX1: ;
			pcorr_pkg::OP_DX2: begin
				ld_ma  = pcorr_pkg::ACC_W'(mag_x);
				ld_mb  = pcorr_pkg::MB_W'(mag_x);
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::SUM_W);
				ld_sub = 1'b1;
				ld_clr = 1'b0;
			end
			pcorr_pkg::OP_DY1: ld_ma = pcorr_pkg::ACC_W'(sum_yy_q);
			pcorr_pkg::OP_DY2: begin
				ld_ma  = pcorr_pkg::ACC_W'(mag_y);
				ld_mb  = pcorr_pkg::MB_W'(mag_y);
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::SUM_W);
				ld_sub = 1'b1;
				ld_clr = 1'b0;
			end
			pcorr_pkg::OP_NUM1: begin
				ld_ma  = pcorr_pkg::ACC_W'(mag_xy);
				ld_sub = sum_xy_q[pcorr_pkg::XY_W-1];
			end
			pcorr_pkg::OP_NUM2: begin
				ld_ma  = pcorr_pkg::ACC_W'(mag_x);
				ld_mb  = pcorr_pkg::MB_W'(mag_y);
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::SUM_W);
				ld_sub = (sum_x_q[pcorr_pkg::SUM_W-1] == sum_y_q[pcorr_pkg::SUM_W-1]);
				ld_clr = 1'b0;
			end
			pcorr_pkg::OP_NEG: begin
				ld_ma  = acc_q;
				ld_mb  = pcorr_pkg::MB_W'(1);
				ld_cnt = pcorr_pkg::STEP_W'(1);
				ld_sub = 1'b1;
			end
			pcorr_pkg::OP_RHS: begin
				ld_ma  = pcorr_pkg::ACC_W'(num_q) << pcorr_pkg::T_W;
				ld_mb  = num_q;
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::VAR_W);
			end
			pcorr_pkg::OP_DEN: begin
				ld_ma  = pcorr_pkg::ACC_W'(dx_q);
				ld_mb  = dy_q;
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::VAR_W);
			end
			pcorr_pkg::OP_TEST: begin
				ld_ma  = pcorr_pkg::ACC_W'(den_q);
				ld_mb  = pcorr_pkg::MB_W'(prod_s1[pcorr_pkg::T_W-1:0]);
				ld_cnt = pcorr_pkg::STEP_W'(pcorr_pkg::T_W);
			end
			default: ;
		endcase
	end

	// control and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pcorr_pkg::S_IDLE;
			op_q           <= pcorr_pkg::OP_DX1;
			pair_cnt_q     <= '0;
			sum_x_q        <= '0;
			sum_y_q        <= '0;
			sum_xx_q       <= '0;
			sum_yy_q       <= '0;
			sum_xy_q       <= '0;
			overflow_q     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			op_q    <= op_nxt;
			if (take_word) begin
				if (pair_cnt_q == pcorr_pkg::CNT_W'(pcorr_pkg::MAX_POINTS)) begin
					overflow_q <= 1'b1;
				end else begin
					pair_cnt_q <= pair_cnt_q + pcorr_pkg::CNT_W'(1);
					sum_x_q    <= sum_x_q + pcorr_pkg::SUM_W'(sample_x);
					sum_y_q    <= sum_y_q + pcorr_pkg::SUM_W'(sample_y);
				end
			end
			if (state_q == pcorr_pkg::S_SQY)
				sum_xx_q <= sum_xx_q + pcorr_pkg::SQ_W'($unsigned(prod_s1));
			if (state_q == pcorr_pkg::S_PXY)
				sum_yy_q <= sum_yy_q + pcorr_pkg::SQ_W'($unsigned(prod_s1));
			if (state_q == pcorr_pkg::S_ADDXY)
				sum_xy_q <= sum_xy_q + pcorr_pkg::XY_W'(prod_s1);
			if (capture) begin
				pair_cnt_q     <= '0;
				sum_x_q        <= '0;
				sum_y_q        <= '0;
				sum_xx_q       <= '0;
				sum_yy_q       <= '0;
				sum_xy_q       <= '0;
				overflow_q     <= 1'b0;
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (take_word) begin
			x_q    <= sample_x;
			y_q    <= sample_y;
			last_q <= last_pair;
		end
		unique case (state_q)
			pcorr_pkg::S_CHECK: begin
				status_q <= overflow_q ? pcorr_pkg::ST_OVER : pcorr_pkg::ST_FEW;
			end
			pcorr_pkg::S_LOAD: begin
				ma_q  <= ld_ma;
				mb_q  <= ld_mb;
				cnt_q <= ld_cnt;
				sub_q <= ld_sub;
				if (ld_clr)
					acc_q <= '0;
			end
			pcorr_pkg::S_RUN: begin
				if (mb_q[0])
					acc_q <= unit_sum;
				ma_q  <= ma_q << 1;
				mb_q  <= mb_q >> 1;
				cnt_q <= cnt_q - pcorr_pkg::STEP_W'(1);
			end
			pcorr_pkg::S_POST: begin
				case (op_q)
					pcorr_pkg::OP_DX2: dx_q <= acc_q[pcorr_pkg::VAR_W-1:0];
					pcorr_pkg::OP_DY2: begin
						dy_q     <= acc_q[pcorr_pkg::VAR_W-1:0];
						status_q <= pcorr_pkg::ST_FLAT;
					end
					pcorr_pkg::OP_NUM2: begin
						neg_q <= acc_q[pcorr_pkg::ACC_W-1];
						num_q <= acc_q[pcorr_pkg::VAR_W-1:0];
					end
					pcorr_pkg::OP_NEG: num_q <= acc_q[pcorr_pkg::VAR_W-1:0];
					pcorr_pkg::OP_RHS: rhs_q <= acc_q;
					pcorr_pkg::OP_DEN: begin
						den_q    <= acc_q[pcorr_pkg::DEN_W-1:0];
						status_q <= pcorr_pkg::ST_OK;
						m_q      <= '0;
						bit_q    <= pcorr_pkg::BIT_W'(pcorr_pkg::CODE_W - 1);
					end
					pcorr_pkg::OP_TEST: begin
						if (acc_q <= rhs_q)
							m_q <= cand;
						bit_q <= bit_q - pcorr_pkg::BIT_W'(1);
					end
					default: ;
				endcase
			end
			pcorr_pkg::S_TSQ: begin
				if (cand_over)
					bit_q <= bit_q - pcorr_pkg::BIT_W'(1);
			end
			default: ;
		endcase
		if (capture) begin
			corr_q       <= corr_val;
			res_status_q <= status_q;
			res_count_q  <= pair_cnt_q;
		end
	end

	assign result_valid = result_valid_q;
	assign correlation  = corr_q;
	assign status       = res_status_q;
	assign pair_count   = res_count_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != pcorr_pkg::ST_OK |-> correlation == '0)
		else $error("nonzero r with error status");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == pcorr_pkg::ST_OK |-> pair_count >= pcorr_pkg::CNT_W'(2))
		else $error("ok status with fewer than two pairs");

	a_run_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcorr_pkg::S_RUN |-> cnt_q != '0)
		else $error("shift-add step count ran out");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> pair_cnt_q == '0 && !overflow_q && sum_xy_q == '0)
		else $error("sums not cleared after result");
`endif

endmodule

FILE: bench/pcorr_checker.sv
// Checker for the Pearson correlation block: watches both channels, predicts
// each result from the accepted pairs and compares it field by field.
// Depends on pcorr_pkg.
`timescale 1ns / 1ps

module pcorr_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     sample_valid,
	input  logic                                     sample_stall,
	input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x,
	input  logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y,
	input  logic                                     last_pair,
	input  logic                                     result_valid,
	input  logic                                     result_stall,
	input  logic signed [pcorr_pkg::CODE_W-1:0]      correlation,
	input  logic [1:0]                               status,
	input  logic [pcorr_pkg::CNT_W-1:0]              pair_count,
	output int                                       fails,
	output int                                       pending
);

	typedef struct packed {
		logic [pcorr_pkg::CODE_W-1:0] r;
		pcorr_pkg::status_t           st;
		logic [pcorr_pkg::CNT_W-1:0]  n;
	} corr_word_t;

	corr_word_t expected_r[$];

	logic [pcorr_pkg::CNT_W-1:0] n_pairs;
	logic signed [63:0]          acc_x, acc_y, acc_xy;
	logic [63:0]                 acc_xx, acc_yy;
	logic                        too_many;

	function automatic logic [255:0] mag256(input logic signed [63:0] v);
		return 256'(v < 0 ? -v : v);
	endfunction

	function automatic corr_word_t close_set();
		corr_word_t   w;
		logic [255:0] nn, mx, my, dx, dy, p, q, num, rhs, den, t;
		logic         p_neg, q_neg, neg;
		logic [16:0]  lo, hi, mid;
		w.r  = '0;
		w.n  = n_pairs;
		w.st = pcorr_pkg::ST_OK;
		if (too_many) begin
			w.st = pcorr_pkg::ST_OVER;
			return w;
		end
		if (n_pairs < 2) begin
			w.st = pcorr_pkg::ST_FEW;
			return w;
		end
		nn = 256'(n_pairs);
		mx = mag256(acc_x);
		my = mag256(acc_y);
		dx = nn * 256'(acc_xx) - mx * mx;
		dy = nn * 256'(acc_yy) - my * my;
		if (dx == 0 || dy == 0) begin
			w.st = pcorr_pkg::ST_FLAT;
			return w;
		end
		p     = nn * mag256(acc_xy);
		p_neg = acc_xy < 0;
		q     = mx * my;
		q_neg = (acc_x < 0) == (acc_y < 0);
		if (p_neg == q_neg) begin
			num = p + q;
			neg = p_neg;
		end else if (p >= q) begin
			num = p - q;
			neg = p_neg;
		end else begin
			num = q - p;
			neg = q_neg;
		end
		rhs = (num * num) << 32;
		den = dx * dy;
		lo  = 0;
		hi  = 17'd32768;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t   = 256'(2 * mid - 1);
			if (t * t * den <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (neg)
			w.r = pcorr_pkg::CODE_W'(17'h10000 - lo);
		else
			w.r = lo > 32767 ? pcorr_pkg::R_MAX : lo[pcorr_pkg::CODE_W-1:0];
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	task automatic clear_sums();
		n_pairs  = '0;
		acc_x    = '0;
		acc_y    = '0;
		acc_xx   = '0;
		acc_yy   = '0;
		acc_xy   = '0;
		too_many = 1'b0;
	endtask

	initial begin
		fails   = 0;
		pending = 0;
		clear_sums();
	end

	always @(posedge clk) begin
		corr_word_t         w;
		logic signed [63:0] x, y;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_r.size() == 0) begin
					report_mismatch("unexpected word, correlation", correlation, 0);
				end else begin
					w = expected_r.pop_front();
					if (correlation !== w.r)
						report_mismatch("correlation", correlation, $signed(w.r));
					if (status !== w.st)
						report_mismatch("status", status, w.st);
					if (pair_count !== w.n)
						report_mismatch("pair_count", pair_count, w.n);
				end
			end
			if (sample_valid && !sample_stall) begin
				x = 64'(sample_x);
				y = 64'(sample_y);
				if (n_pairs >= pcorr_pkg::MAX_POINTS) begin
					too_many = 1'b1;
				end else begin
					n_pairs++;
					acc_x  += x;
					acc_y  += y;
					acc_xx += x * x;
					acc_yy += y * y;
					acc_xy += x * y;
				end
				if (last_pair) begin
					expected_r.insert(expected_r.size(), close_set());
					clear_sums();
				end
			end
			pending = expected_r.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// Testbench top for pearson_correlation: drives sets of sample pairs with
// bursty gaps and a stalling receiver, and gives the verdict.
// Depends on pcorr_pkg, pearson_correlation and pcorr_checker.
`timescale 1ns / 1ps

module tb_top;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int SMAX = 8388607;

	logic                                     clk;
	logic                                     arst_n;
	logic                                     sample_valid;
	logic                                     sample_stall;
	logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_x;
	logic signed [pcorr_pkg::SAMPLE_BITS-1:0] sample_y;
	logic                                     last_pair;
	logic                                     result_valid;
	logic                                     result_stall;
	logic signed [pcorr_pkg::CODE_W-1:0]      correlation;
	logic [1:0]                               status;
	logic [pcorr_pkg::CNT_W-1:0]              pair_count;
	int                                       fails;
	int                                       pending;
	int                                       cycles;
	int                                       burst_left;

	pearson_correlation u_top (.*);

	pcorr_checker u_chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver: random stall pattern, one long hold-off early in the random part
	initial begin
		int  len, kind;
		bit  held;
		held = 0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			len  = $urandom_range(1, 60);
			kind = $urandom_range(0, 3);
			if (!held && cycles > 8000) begin
				held = 1;
				repeat (5000) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end else begin
				repeat (len) begin
					@(posedge clk);
					case (kind)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 1) == 0);
						2: result_stall <= ($urandom_range(0, 4) != 0);
						default: result_stall <= ($urandom_range(0, 4) == 0);
					endcase
				end
			end
		end
	end

	task automatic send_pair(input int x, input int y, input bit last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		sample_valid <= 1'b1;
		sample_x     <= x[pcorr_pkg::SAMPLE_BITS-1:0];
		sample_y     <= y[pcorr_pkg::SAMPLE_BITS-1:0];
		last_pair    <= last;
		do
			@(posedge clk);
		while (sample_stall);
	endtask

	function automatic int pick(input int mode);
		case (mode)
			0: return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
			1: return $urandom_range(0, 200) - 100;
			default: return $urandom_range(0, 2000000) - 1000000;
		endcase
	endfunction

	initial begin
		int sent, size, mode, x, y, cx, slope;
		sample_valid = 1'b0;
		sample_x     = '0;
		sample_y     = '0;
		last_pair    = 1'b0;
		burst_left   = 0;
		arst_n       = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single pair, extremes
		send_pair(SMAX, -SMAX - 1, 1);
		// flat x
		send_pair(5, 1, 0);
		send_pair(5, -7, 1);
		// flat y
		send_pair(-SMAX - 1, 3, 0);
		send_pair(SMAX, 3, 1);
		// y = x, saturating +1
		send_pair(-SMAX - 1, -SMAX - 1, 0);
		send_pair(SMAX, SMAX, 0);
		send_pair(0, 0, 1);
		// y = -x, gives -1
		send_pair(SMAX, -SMAX, 0);
		send_pair(-SMAX, SMAX, 0);
		send_pair(1, -1, 1);
		// general set
		send_pair(100, 40, 0);
		send_pair(-3000, 2, 0);
		send_pair(77777, -123456, 0);
		send_pair(-1, SMAX, 1);
		// two identical pairs: flat both ways
		send_pair(-42, -42, 0);
		send_pair(-42, -42, 1);

		sent = 0;
		while (sent < 950) begin
			case ($urandom_range(0, 9))
				0: size = 1;
				1: size = $urandom_range(11, 40);
				default: size = $urandom_range(2, 10);
			endcase
			mode  = $urandom_range(0, 4);
			cx    = pick(mode % 3);
			slope = $urandom_range(0, 6) - 3;
			for (int i = 0; i < size; i++) begin
				x = (mode == 4) ? cx : pick(mode % 3);
				if (mode == 3)
					y = x * slope + $urandom_range(0, 20) - 10;
				else
					y = pick($urandom_range(0, 2));
				send_pair(x, y, i == size - 1);
				sent++;
			end
		end
		sample_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
